>>> rtl/swcr_pkg.sv
// Package for the stop-and-wait checksum receiver.
// Holds the field widths, the default buffer depth and the controller/datapath structs.
// No dependencies.
package swcr_pkg;

  localparam int PAYLOAD_BYTES_DEF = 32;
  localparam int LEN_W  = 8;
  localparam int BYTE_W = 8;
  localparam int SUM_W  = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;      // an input transfer completes this cycle
    logic rd_issue;  // read the next buffered byte
    logic rd_move;   // move the read byte into the output register
  } swcr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // output register can be loaded this cycle
    logic drain_req;   // the offered item would close a packet with an ACK
    logic issue_left;  // buffered bytes remain to be read
    logic rd_valid;    // read data holds a byte not yet moved out
  } swcr_sts_t;

endpackage

>>> rtl/stop_wait_checksum_receiver_top.sv
// Top level of the stop-and-wait checksum receiver.
// Joins swcr_ctrl and swcr_dpath; depends on swcr_pkg.
//
// Usage: the input channel carries packet headers (kind, length, checksum)
// and payload bytes, one transfer per item. Each byte of an open packet is
// buffered and its sign-extended value added into a 32-bit wrapping sum.
// When the declared length is reached, or at once for a zero-length header,
// the sum is checked and one response (ACK or NACK) is loaded into the
// output register in the cycle of the closing transfer, so it shows the
// next cycle. A header longer than the buffer gets an immediate NACK.
// On an ACK the buffered bytes follow in arrival order after the first
// buffer read, one per cycle while the output is not stalled; last marks
// the final result. Throughput: one input transfer per cycle while the
// output register is free and no drain runs. After an ACK the input is
// stalled while its bytes pass through the one read port of the buffer.
// Bytes with no open packet and headers that open a packet give no result.
// Reset clears all control state with no clearing pass; buffer entries are
// only read after being written in the same packet. When the receiver
// stalls the output, the result holds and in_stall_o rises in the same cycle.
module stop_wait_checksum_receiver_top import swcr_pkg::*; #(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    req_type_i,
  input  logic                    packet_kind_i,
  input  logic [LEN_W-1:0]        payload_length_i,
  input  logic signed [SUM_W-1:0] sent_checksum_i,
  input  logic [BYTE_W-1:0]       byte_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    result_kind_o,
  output logic                    ack_o,
  output logic [BYTE_W-1:0]       data_byte_o,
  output logic                    message_done_o,
  output logic                    last_o
);

  swcr_cmd_t cmd;
  swcr_sts_t sts;

  // The controller owns the handshake decision and the drain sequencing.
  swcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // The datapath holds packet state, the checksum adder, the buffer and the output register.
  swcr_dpath #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_type_i       (req_type_i),
    .packet_kind_i    (packet_kind_i),
    .payload_length_i (payload_length_i),
    .sent_checksum_i  (sent_checksum_i),
    .byte_value_i     (byte_value_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .result_kind_o    (result_kind_o),
    .ack_o            (ack_o),
    .data_byte_o      (data_byte_o),
    .message_done_o   (message_done_o),
    .last_o           (last_o)
  );

endmodule

>>> rtl/swcr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds while the read enable is low. No dependencies.
module swcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/swcr_ctrl.sv
// Controller of the stop-and-wait checksum receiver.
// Decides when input transfers are taken and sequences the buffer drain.
// Depends on swcr_pkg.
module swcr_ctrl import swcr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  swcr_sts_t sts_i,
  output logic      in_stall_o,
  output swcr_cmd_t cmd_o
);

  localparam logic StIdle  = 1'b0;
  localparam logic StDrain = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      StIdle: begin
        in_stall_o = !sts_i.out_free;
        cmd_o.take = in_valid_i && sts_i.out_free;
        if (cmd_o.take && sts_i.drain_req) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        cmd_o.rd_issue = sts_i.issue_left && (!sts_i.rd_valid || sts_i.out_free);
        cmd_o.rd_move  = sts_i.rd_valid && sts_i.out_free;
        // The byte in the read register is the final one once nothing is left to issue.
        if (cmd_o.rd_move && !sts_i.issue_left) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/swcr_dpath.sv
// Datapath of the stop-and-wait checksum receiver: packet registers, checksum
// adder, payload buffer and output register. Depends on swcr_pkg and swcr_ram.
module swcr_dpath import swcr_pkg::*; #(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  swcr_cmd_t               cmd_i,
  output swcr_sts_t               sts_o,
  input  logic                    req_type_i,
  input  logic                    packet_kind_i,
  input  logic [LEN_W-1:0]        payload_length_i,
  input  logic signed [SUM_W-1:0] sent_checksum_i,
  input  logic [BYTE_W-1:0]       byte_value_i,
  input  logic                    out_stall_i,
  output logic                    out_valid_o,
  output logic                    result_kind_o,
  output logic                    ack_o,
  output logic [BYTE_W-1:0]       data_byte_o,
  output logic                    message_done_o,
  output logic                    last_o
);

  localparam int AddrW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int CntW  = $clog2(PAYLOAD_BYTES + 1);

  // Packet state.
  logic             open_q, open_d;
  logic [CntW-1:0]  seen_q, seen_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [SUM_W-1:0] chk_q, chk_d;
  logic             kind_q, kind_d;
  // Drain state.
  logic             done_q, done_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  logic             rv_q, rv_d;
  logic             rv_last_q, rv_last_d;
  // Output register.
  logic              out_valid_q, out_valid_d;
  logic              res_kind_q, res_kind_d;
  logic              ack_q, ack_d;
  logic [BYTE_W-1:0] data_q, data_d;
  logic              mdone_q, mdone_d;
  logic              last_q, last_d;

  logic [SUM_W-1:0]  sum_add;
  logic [CntW-1:0]   seen_inc;
  logic              fin_byte;
  logic              good_byte;
  logic              too_long;
  logic              zero_len;
  logic              good_zero;
  logic              we;
  logic [BYTE_W-1:0] rdata;

  assign sum_add   = sum_q + {{(SUM_W-BYTE_W){byte_value_i[BYTE_W-1]}}, byte_value_i};
  assign seen_inc  = seen_q + 1'b1;
  assign fin_byte  = LEN_W'(seen_inc) >= len_q;
  assign good_byte = sum_add == chk_q;
  assign too_long  = payload_length_i > LEN_W'(PAYLOAD_BYTES);
  assign zero_len  = payload_length_i == '0;
  assign good_zero = sent_checksum_i == '0;

  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign sts_o.drain_req  = req_type_i && open_q && fin_byte && good_byte;
  assign sts_o.issue_left = LEN_W'(rd_idx_q) != len_q;
  assign sts_o.rd_valid   = rv_q;

  always_comb begin
    open_d      = open_q;
    seen_d      = seen_q;
    len_d       = len_q;
    sum_d       = sum_q;
    chk_d       = chk_q;
    kind_d      = kind_q;
    done_d      = done_q;
    rd_idx_d    = rd_idx_q;
    rv_d        = rv_q;
    rv_last_d   = rv_last_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_kind_d  = res_kind_q;
    ack_d       = ack_q;
    data_d      = data_q;
    mdone_d     = mdone_q;
    last_d      = last_q;
    we          = 1'b0;

    if (cmd_i.take) begin
      if (!req_type_i) begin
        // A header always restarts the packet, dropping any open one silently.
        open_d = 1'b0;
        seen_d = '0;
        sum_d  = '0;
        len_d  = payload_length_i;
        chk_d  = sent_checksum_i;
        kind_d = packet_kind_i;
        if (too_long) begin
          len_d       = '0;
          out_valid_d = 1'b1;
          res_kind_d  = 1'b0;
          ack_d       = 1'b0;
          data_d      = '0;
          mdone_d     = 1'b0;
          last_d      = 1'b1;
        end else if (zero_len) begin
          out_valid_d = 1'b1;
          res_kind_d  = 1'b0;
          ack_d       = good_zero;
          data_d      = '0;
          mdone_d     = good_zero && packet_kind_i;
          last_d      = 1'b1;
        end else begin
          open_d = 1'b1;
        end
      end else if (open_q) begin
        we     = 1'b1;
        sum_d  = sum_add;
        seen_d = seen_inc;
        if (fin_byte) begin
          open_d      = 1'b0;
          seen_d      = '0;
          done_d      = good_byte && kind_q;
          rd_idx_d    = '0;
          out_valid_d = 1'b1;
          res_kind_d  = 1'b0;
          ack_d       = good_byte;
          data_d      = '0;
          mdone_d     = good_byte && kind_q;
          last_d      = !good_byte;
        end
      end
    end

    if (cmd_i.rd_issue) begin
      rd_idx_d  = rd_idx_q + 1'b1;
      rv_d      = 1'b1;
      rv_last_d = (LEN_W'(rd_idx_q) + LEN_W'(1)) == len_q;
    end else if (cmd_i.rd_move) begin
      rv_d = 1'b0;
    end

    if (cmd_i.rd_move) begin
      out_valid_d = 1'b1;
      res_kind_d  = 1'b1;
      ack_d       = 1'b0;
      data_d      = rdata;
      mdone_d     = done_q;
      last_d      = rv_last_q;
    end
  end

  swcr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PAYLOAD_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (seen_q[AddrW-1:0]),
    .wdata_i (byte_value_i),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (rd_idx_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      seen_q      <= '0;
      len_q       <= '0;
      sum_q       <= '0;
      chk_q       <= '0;
      kind_q      <= 1'b0;
      done_q      <= 1'b0;
      rd_idx_q    <= '0;
      rv_q        <= 1'b0;
      rv_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      open_q      <= open_d;
      seen_q      <= seen_d;
      len_q       <= len_d;
      sum_q       <= sum_d;
      chk_q       <= chk_d;
      kind_q      <= kind_d;
      done_q      <= done_d;
      rd_idx_q    <= rd_idx_d;
      rv_q        <= rv_d;
      rv_last_q   <= rv_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_kind_q <= res_kind_d;
    ack_q      <= ack_d;
    data_q     <= data_d;
    mdone_q    <= mdone_d;
    last_q     <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = res_kind_q;
  assign ack_o          = ack_q;
  assign data_byte_o    = data_q;
  assign message_done_o = mdone_q;
  assign last_o         = last_q;

endmodule

>>> rtl/swcr_checker.sv
// Port-level checker for the stop-and-wait checksum receiver, with its bind.
// Depends on swcr_pkg and stop_wait_checksum_receiver_top.
module swcr_checker import swcr_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              result_kind_o,
  input logic              ack_o,
  input logic [BYTE_W-1:0] data_byte_o,
  input logic              message_done_o,
  input logic              last_o
);

  // A stalled result keeps its valid and its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_kind_o) &&
      $stable(ack_o) && $stable(data_byte_o) && $stable(message_done_o) && $stable(last_o))
    else $error("stalled result changed");

  // A NACK never opens a run of delivered bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_kind_o && !ack_o |-> last_o)
    else $error("NACK not marked last");

  // Message completion is only reported on an accepted packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_kind_o && message_done_o |-> ack_o)
    else $error("message done without ACK");

  // While bytes are still being delivered the input side is held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o && !last_o |-> in_stall_o)
    else $error("input taken during drain");

endmodule

bind stop_wait_checksum_receiver_top swcr_checker u_swcr_checker (.*);
